// ===== design/sparse_set_component_store_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sparse-set component store.
// Concurrent checks sampled on the rising clock, held off during reset.
// ----------------------------------------------------------------------------
`ifndef SPARSE_SET_COMPONENT_STORE_DEFINES_SVH
`define SPARSE_SET_COMPONENT_STORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSC_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SSC_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ssc_pkg.sv =====
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared types and field widths of the sparse-set component store.
// ----------------------------------------------------------------------------
package ssc_pkg;

  // Fixed widths of the command and result fields.
  localparam int TYPE_FIELD_W   = 3;
  localparam int ENTITY_FIELD_W = 10;
  localparam int PAYLOAD_W      = 64;
  localparam int SLOT_FIELD_W   = 10;
  localparam int COUNT_FIELD_W  = 11;
  localparam int CFG_W          = 3;

  // Number of distinct codes the type and entity fields can carry.
  localparam int TYPE_SPACE   = 1 << TYPE_FIELD_W;
  localparam int ENTITY_SPACE = 1 << ENTITY_FIELD_W;

  // Request codes. A probe is a lookup that returns no data.
  typedef enum logic [1:0] {
    REQ_PUSH   = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_LOOKUP = 2'd2,
    REQ_PROBE  = 2'd3
  } req_code_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_TYPE = 2'd1,
    ST_FULL     = 2'd2,
    ST_DUP      = 2'd3
  } status_t;

  // Request sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SPARSE,
    S_DENSE,
    S_MOVE,
    S_UNLINK
  } state_t;

  // Read and write enables of one memory port.
  typedef struct packed {
    logic rd;
    logic wr;
  } mem_op_t;

  // Command beat.
  typedef struct packed {
    req_code_t                   req_type;
    logic [TYPE_FIELD_W-1:0]     component_type;
    logic [ENTITY_FIELD_W-1:0]   entity;
    logic [PAYLOAD_W-1:0]        payload;
  } cmd_t;

  // Result beat.
  typedef struct packed {
    logic                        found;
    logic [PAYLOAD_W-1:0]        read_data;
    logic [SLOT_FIELD_W-1:0]     slot;
    logic [COUNT_FIELD_W-1:0]    member_count;
    status_t                     status;
  } rsp_t;

endpackage

// ===== design/ssc_sparse_map.sv =====
// ----------------------------------------------------------------------------
// ssc_sparse_map
// Single-port sparse map memory with a clearing sweep after reset.
// ----------------------------------------------------------------------------
module ssc_sparse_map
  import ssc_pkg::*;
#(
  parameter int ADDR_WIDTH  = 13,
  parameter int ENTRY_WIDTH = 11
) (
  input  logic                   clk,
  input  logic                   rst,
  input  mem_op_t                op,
  input  logic [ADDR_WIDTH-1:0]  addr,
  input  logic [ENTRY_WIDTH-1:0] wdata,
  output logic [ENTRY_WIDTH-1:0] rdata,
  output logic                   clearing
);

  localparam int DEPTH = 1 << ADDR_WIDTH;

  logic [ENTRY_WIDTH-1:0] mem [DEPTH];
  logic [ADDR_WIDTH-1:0]  clr_addr;

  // Sweep pointer: one entry is cleared per cycle until the top address.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + ADDR_WIDTH'(1);
      if (clr_addr == {ADDR_WIDTH{1'b1}}) begin
        clearing <= 1'b0;
      end
    end
  end

  // Write port, shared between the sweep and the sequencer.
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (op.wr) begin
      mem[addr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (op.rd) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== design/sparse_set_component_store.sv =====
// ----------------------------------------------------------------------------
// sparse_set_component_store
// One sparse set per component type with push, swap-remove and lookup.
// ----------------------------------------------------------------------------
//
// Channel   Signals                         Handshake
// command   start, busy, cmd                beat taken when start and not busy
// result    done, rsp                       one-cycle strobe, no back pressure
// config    cfg_valid, cfg_ready, cfg_data  beat taken when valid and ready
//
// A request with an invalid type or entity is answered from the idle state, a
// push, a probe, a lookup miss or a remove that moves nothing in the sparse
// read step, a lookup hit after a dense read and a remove that moves the last
// element after move and unlink steps; the single-port sparse and dense
// memories set these steps. The result shows one cycle after the last step,
// in the cycle the next command may be taken. After reset, busy stays high
// while the sparse map is swept clear. The receiver cannot stall the result.
//
`include "sparse_set_component_store_defines.svh"

module sparse_set_component_store
  import ssc_pkg::*;
#(
  parameter int ENTITY_COUNT = 1024,
  parameter int TYPE_COUNT   = 8,
  parameter int SET_CAPACITY = 1024,
  parameter int DATA_WIDTH   = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  cmd_t             cmd,
  output logic             done,
  output rsp_t             rsp,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  // Sizes that the field widths can actually reach.
  localparam int TYPE_EFF = (TYPE_COUNT < TYPE_SPACE) ? TYPE_COUNT : TYPE_SPACE;
  localparam int ENT_EFF  = (ENTITY_COUNT < ENTITY_SPACE) ? ENTITY_COUNT : ENTITY_SPACE;
  localparam int TW       = (TYPE_EFF > 1) ? $clog2(TYPE_EFF) : 1;
  localparam int EW       = (ENT_EFF > 1) ? $clog2(ENT_EFF) : 1;
  localparam int SW       = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;
  localparam int CW       = $clog2(SET_CAPACITY + 1);
  localparam int DW       = DATA_WIDTH;
  localparam int SPA_W    = TW + EW;
  localparam int SPE_W    = SW + 1;
  localparam int DNA_W    = TW + SW;
  localparam int DNE_W    = EW + DW;
  localparam int DN_DEPTH = 1 << DNA_W;
  localparam int NSETS    = 1 << TW;

  // Width adapters for the result fields.
  function automatic logic [SLOT_FIELD_W-1:0] slot_field(logic [SW-1:0] s);
    logic [31:0] w;
    w = 32'(s);
    return w[SLOT_FIELD_W-1:0];
  endfunction

  function automatic logic [COUNT_FIELD_W-1:0] count_field(logic [CW-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    return w[COUNT_FIELD_W-1:0];
  endfunction

  state_t              state;
  state_t              state_next;
  logic [CFG_W-1:0]    types_registered;
  logic [CW-1:0]       set_size [NSETS];

  // Latched request.
  req_code_t           r_req;
  logic [TW-1:0]       r_ty;
  logic [EW-1:0]       r_ent;
  logic [DW-1:0]       r_data;
  logic [SW-1:0]       r_slot;
  logic [CW-1:0]       r_size;

  // Memory ports.
  mem_op_t             sp_op;
  logic [SPA_W-1:0]    sp_addr;
  logic [SPE_W-1:0]    sp_wdata;
  logic [SPE_W-1:0]    sp_rdata;
  logic                clearing;
  mem_op_t             dn_op;
  logic [DNA_W-1:0]    dn_addr;
  logic [DNE_W-1:0]    dn_wdata;
  logic [DNE_W-1:0]    dn_rdata;
  logic [DNE_W-1:0]    dense_mem [DN_DEPTH];

  // Set size update and result staging.
  logic                size_we;
  logic [CW-1:0]       size_val;
  logic                done_next;
  rsp_t                rsp_next;

  // Decode of the command and of the sparse entry.
  logic                accept;
  logic                cmd_ok;
  logic [TW-1:0]       cmd_ty;
  logic [EW-1:0]       cmd_ent;
  logic                sp_valid;
  logic [SW-1:0]       sp_slot;
  logic [CW-1:0]       cur_size;
  logic [CW-1:0]       last_cnt;
  logic                present;
  logic                set_full;
  logic                at_last;
  logic [EW-1:0]       mover;

  assign busy      = clearing || (state != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  assign cmd_ty  = cmd.component_type[TW-1:0];
  assign cmd_ent = cmd.entity[EW-1:0];
  assign cmd_ok  = (cmd.component_type != '0) &&
                   (cmd.component_type <= types_registered) &&
                   (32'(cmd.component_type) < TYPE_COUNT) &&
                   (32'(cmd.entity) < ENTITY_COUNT);

  assign sp_valid = sp_rdata[SW];
  assign sp_slot  = sp_rdata[SW-1:0];
  assign cur_size = set_size[r_ty];
  assign last_cnt = cur_size - CW'(1);
  assign present  = sp_valid && (CW'(sp_slot) < cur_size);
  assign set_full = cur_size >= CW'(SET_CAPACITY);
  assign at_last  = sp_slot == last_cnt[SW-1:0];
  assign mover    = dn_rdata[DNE_W-1:DW];

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      types_registered <= '0;
    end else if (cfg_valid && cfg_ready) begin
      types_registered <= cfg_data;
    end
  end

  // Request capture at accept, slot and size capture after the sparse read.
  always_ff @(posedge clk) begin
    if (accept) begin
      r_req  <= cmd.req_type;
      r_ty   <= cmd_ty;
      r_ent  <= cmd_ent;
      r_data <= cmd.payload[DW-1:0];
    end
    if (state == S_SPARSE) begin
      r_slot <= sp_slot;
      r_size <= cur_size;
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && cmd_ok) begin
          state_next = S_SPARSE;
        end
      end
      S_SPARSE: begin
        state_next = S_IDLE;
        if (r_req == REQ_REMOVE && present && !at_last) begin
          state_next = S_MOVE;
        end else if (r_req == REQ_LOOKUP && present) begin
          state_next = S_DENSE;
        end
      end
      S_DENSE:  state_next = S_IDLE;
      S_MOVE:   state_next = S_UNLINK;
      S_UNLINK: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Memory commands, set size updates and the staged result.
  always_comb begin
    sp_op     = '0;
    sp_addr   = {r_ty, r_ent};
    sp_wdata  = '0;
    dn_op     = '0;
    dn_addr   = {r_ty, r_slot};
    dn_wdata  = dn_rdata;
    size_we   = 1'b0;
    size_val  = cur_size;
    done_next = 1'b0;
    rsp_next  = '0;
    unique case (state)
      S_IDLE: begin
        sp_addr = {cmd_ty, cmd_ent};
        if (accept) begin
          if (cmd_ok) begin
            sp_op.rd = 1'b1;
          end else begin
            done_next       = 1'b1;
            rsp_next.status = ST_BAD_TYPE;
          end
        end
      end
      S_SPARSE: begin
        rsp_next.member_count = count_field(cur_size);
        case (r_req)
          REQ_PUSH: begin
            if (present) begin
              done_next         = 1'b1;
              rsp_next.found    = 1'b1;
              rsp_next.slot     = slot_field(sp_slot);
              rsp_next.status   = ST_DUP;
            end else if (set_full) begin
              done_next         = 1'b1;
              rsp_next.status   = ST_FULL;
            end else begin
              // Append at the end of the dense arrays and link the entity.
              dn_op.wr          = 1'b1;
              dn_addr           = {r_ty, cur_size[SW-1:0]};
              dn_wdata          = {r_ent, r_data};
              sp_op.wr          = 1'b1;
              sp_wdata          = {1'b1, cur_size[SW-1:0]};
              size_we           = 1'b1;
              size_val          = cur_size + CW'(1);
              done_next         = 1'b1;
              rsp_next.slot     = slot_field(cur_size[SW-1:0]);
              rsp_next.member_count = count_field(cur_size + CW'(1));
            end
          end
          REQ_REMOVE: begin
            if (!present) begin
              done_next = 1'b1;
            end else if (!at_last) begin
              // Fetch the last element so it can fill the freed slot.
              dn_op.rd = 1'b1;
              dn_addr  = {r_ty, last_cnt[SW-1:0]};
            end else begin
              sp_op.wr              = 1'b1;
              size_we               = 1'b1;
              size_val              = last_cnt;
              done_next             = 1'b1;
              rsp_next.found        = 1'b1;
              rsp_next.slot         = slot_field(sp_slot);
              rsp_next.member_count = count_field(last_cnt);
            end
          end
          REQ_LOOKUP: begin
            if (present) begin
              dn_op.rd = 1'b1;
              dn_addr  = {r_ty, sp_slot};
            end else begin
              done_next = 1'b1;
            end
          end
          default: begin
            // Probe: membership and slot without data.
            done_next      = 1'b1;
            rsp_next.found = present;
            rsp_next.slot  = present ? slot_field(sp_slot) : '0;
          end
        endcase
      end
      S_DENSE: begin
        done_next             = 1'b1;
        rsp_next.found        = 1'b1;
        rsp_next.read_data    = 64'(dn_rdata[DW-1:0]);
        rsp_next.slot         = slot_field(r_slot);
        rsp_next.member_count = count_field(r_size);
      end
      S_MOVE: begin
        // Move the last element into the freed slot and relink its owner.
        dn_op.wr = 1'b1;
        dn_addr  = {r_ty, r_slot};
        dn_wdata = dn_rdata;
        sp_op.wr = 1'b1;
        sp_addr  = {r_ty, mover};
        sp_wdata = {1'b1, r_slot};
      end
      S_UNLINK: begin
        sp_op.wr              = 1'b1;
        size_we               = 1'b1;
        size_val              = r_size - CW'(1);
        done_next             = 1'b1;
        rsp_next.found        = 1'b1;
        rsp_next.slot         = slot_field(r_slot);
        rsp_next.member_count = count_field(r_size - CW'(1));
      end
      default: begin
        done_next = 1'b0;
      end
    endcase
  end

  // Per-type set sizes.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NSETS; i++) begin
        set_size[i] <= '0;
      end
    end else if (size_we) begin
      set_size[r_ty] <= size_val;
    end
  end

  // Dense owner and data memory, one port, registered read.
  always_ff @(posedge clk) begin
    if (dn_op.wr) begin
      dense_mem[dn_addr] <= dn_wdata;
    end
    if (dn_op.rd) begin
      dn_rdata <= dense_mem[dn_addr];
    end
  end

  // Sparse map with its clearing sweep.
  ssc_sparse_map #(
    .ADDR_WIDTH  (SPA_W),
    .ENTRY_WIDTH (SPE_W)
  ) u_sparse (
    .clk      (clk),
    .rst      (rst),
    .op       (sp_op),
    .addr     (sp_addr),
    .wdata    (sp_wdata),
    .rdata    (sp_rdata),
    .clearing (clearing)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (done_next) begin
      rsp <= rsp_next;
    end
  end

  // Checks on the sequencer.
  `SSC_ASSERT_NOW(a_clear_holds_busy, clk, rst, clearing, busy, "port open in sweep")
  `SSC_ASSERT_NOW(a_idle_no_write, clk, rst, state == S_IDLE, !sp_op.wr && !dn_op.wr, "idle write")
  `SSC_ASSERT_NOW(a_done_when_idle, clk, rst, done, !busy, "result while busy")
  `SSC_ASSERT_NEXT(a_accept_reads_map, clk, rst, accept && cmd_ok, state == S_SPARSE, "no map read")

endmodule

// ===== dv/ssc_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_result_checker
// Watches the command, result and register channels of the sparse-set
// component store. It keeps its own copy of every set, works out the result
// of each accepted command beat and compares it field by field with the
// result beats in order.
// ----------------------------------------------------------------------------
module ssc_result_checker
  import ssc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  cmd_t             cmd,
  input  logic             done,
  input  rsp_t             rsp,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data,
  output int               errors,
  output int               pending,
  output int               results_seen
);

  localparam int SET_CAP  = 1024;
  localparam int MAP_SIZE = TYPE_SPACE * ENTITY_SPACE;
  localparam int MAX_SHOWN = 10;

  // Shadow copy of the sparse map, the dense stores and the set sizes.
  bit                        linked     [MAP_SIZE];
  logic [COUNT_FIELD_W-1:0]  link_slot  [MAP_SIZE];
  logic [ENTITY_FIELD_W-1:0] slot_owner [TYPE_SPACE*SET_CAP];
  logic [PAYLOAD_W-1:0]      slot_word  [TYPE_SPACE*SET_CAP];
  logic [COUNT_FIELD_W-1:0]  members    [TYPE_SPACE];
  logic [CFG_W-1:0]          types_reg;

  // Results owed by the block, oldest first.
  rsp_t rsp_due [$];

  // Applies one command to the shadow sets and returns the result it causes.
  function automatic rsp_t store_apply(input cmd_t c);
    rsp_t r;
    int ty, sidx, dbase, last, mover;
    logic [COUNT_FIELD_W-1:0] size, slt;
    bit present;
    r = '0;
    r.status = ST_OK;
    ty = int'(c.component_type);
    if (ty == 0 || ty > int'(types_reg)) begin
      r.status = ST_BAD_TYPE;
      return r;
    end
    sidx    = ty * ENTITY_SPACE + int'(c.entity);
    dbase   = ty * SET_CAP;
    size    = members[ty];
    slt     = link_slot[sidx];
    present = linked[sidx] && (slt < size);
    r.member_count = size;
    case (c.req_type)
      REQ_PUSH: begin
        if (present) begin
          r.found  = 1'b1;
          r.slot   = slt[SLOT_FIELD_W-1:0];
          r.status = ST_DUP;
        end else if (int'(size) >= SET_CAP) begin
          r.status = ST_FULL;
        end else begin
          slot_word[dbase + int'(size)]  = c.payload;
          slot_owner[dbase + int'(size)] = c.entity;
          linked[sidx]    = 1'b1;
          link_slot[sidx] = size;
          members[ty]     = size + COUNT_FIELD_W'(1);
          r.slot          = size[SLOT_FIELD_W-1:0];
          r.member_count  = size + COUNT_FIELD_W'(1);
        end
      end
      REQ_REMOVE: begin
        if (present) begin
          last = int'(size) - 1;
          // The last element fills the hole unless it is the one removed.
          if (int'(slt) != last) begin
            mover = int'(slot_owner[dbase + last]);
            slot_word[dbase + int'(slt)]  = slot_word[dbase + last];
            slot_owner[dbase + int'(slt)] = ENTITY_FIELD_W'(mover);
            linked[ty * ENTITY_SPACE + mover]    = 1'b1;
            link_slot[ty * ENTITY_SPACE + mover] = slt;
          end
          linked[sidx]   = 1'b0;
          members[ty]    = COUNT_FIELD_W'(last);
          r.found        = 1'b1;
          r.slot         = slt[SLOT_FIELD_W-1:0];
          r.member_count = COUNT_FIELD_W'(last);
        end
      end
      default: begin
        // Lookup and probe; only a lookup returns the data word.
        if (present) begin
          r.found = 1'b1;
          r.slot  = slt[SLOT_FIELD_W-1:0];
          if (c.req_type == REQ_LOOKUP) r.read_data = slot_word[dbase + int'(slt)];
        end
      end
    endcase
    return r;
  endfunction

  // Reports one bad result beat, in detail for the first few only.
  task automatic flag(input string what, input rsp_t want, input rsp_t got);
    if (errors < MAX_SHOWN) begin
      $display("%0t: %s", $realtime, what);
      $display("  expected found=%0d data=%h slot=%0d count=%0d status=%0d",
               want.found, want.read_data, want.slot, want.member_count, want.status);
      $display("  actual   found=%0d data=%h slot=%0d count=%0d status=%0d",
               got.found, got.read_data, got.slot, got.member_count, got.status);
    end
    errors++;
  endtask

  // Sample all channels at the rising edge.
  always @(posedge clk) begin : watch
    rsp_t want;
    if (rst) begin
      foreach (linked[i]) linked[i] = 1'b0;
      foreach (members[i]) members[i] = '0;
      types_reg = '0;
      rsp_due.delete();
      errors       = 0;
      results_seen = 0;
    end else begin
      // Result beat first: it may be taken at the edge that takes a command.
      if (done) begin
        results_seen++;
        if (rsp_due.size() == 0) begin
          flag("result beat with nothing outstanding", '0, rsp);
        end else begin
          want = rsp_due.pop_front();
          if (rsp.found !== want.found || rsp.read_data !== want.read_data ||
              rsp.slot !== want.slot || rsp.member_count !== want.member_count ||
              rsp.status !== want.status)
            flag("result beat mismatch", want, rsp);
        end
      end
      // A register beat only affects commands taken at later edges.
      if (start && !busy) rsp_due.insert(rsp_due.size(), store_apply(cmd));
      if (cfg_valid && cfg_ready) types_reg = cfg_data;
    end
    pending = rsp_due.size();
  end

endmodule

// ===== dv/sparse_set_component_store_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_set_component_store_tb
// Drives command and register beats into the sparse-set component store:
// a directed opening and random phases under several type counts. The
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module sparse_set_component_store_tb
  import ssc_pkg::*;
();

  localparam int POOL_SIZE = 16;
  localparam int TAIL      = 20;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  cmd_t             cmd;
  logic             done;
  rsp_t             rsp;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data;

  int chk_errors;
  int chk_pending;
  int chk_results;

  int                        sent;
  logic [CFG_W-1:0]          cur_types;
  logic [ENTITY_FIELD_W-1:0] pool [POOL_SIZE];

  sparse_set_component_store dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .done      (done),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  ssc_result_checker chk (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .done         (done),
    .rsp          (rsp),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .errors       (chk_errors),
    .pending      (chk_pending),
    .results_seen (chk_results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Timeout that ends the run and reports errors if the stimulus hangs.
  initial begin
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic cmd_t make_cmd(input req_code_t r, input int ty, input int ent,
                                    input logic [PAYLOAD_W-1:0] p);
    cmd_t c;
    c.req_type       = r;
    c.component_type = ty[TYPE_FIELD_W-1:0];
    c.entity         = ent[ENTITY_FIELD_W-1:0];
    c.payload        = p;
    return c;
  endfunction

  // Mostly commands on a small entity pool so sets fill and get hits;
  // the rest is noise over the whole field space.
  function automatic cmd_t random_cmd();
    cmd_t c;
    int pick;
    c.payload = {$urandom, $urandom};
    if ($urandom_range(99, 0) < 10) begin
      c.req_type       = req_code_t'(2'($urandom_range(3, 0)));
      c.component_type = TYPE_FIELD_W'($urandom_range(TYPE_SPACE - 1, 0));
      c.entity         = ENTITY_FIELD_W'($urandom_range(ENTITY_SPACE - 1, 0));
    end else begin
      pick = $urandom_range(99, 0);
      if (pick < 35)      c.req_type = REQ_PUSH;
      else if (pick < 60) c.req_type = REQ_REMOVE;
      else if (pick < 90) c.req_type = REQ_LOOKUP;
      else                c.req_type = REQ_PROBE;
      c.component_type = (cur_types == 0) ? '0 :
                         TYPE_FIELD_W'($urandom_range(int'(cur_types), 1));
      c.entity         = pool[$urandom_range(POOL_SIZE - 1, 0)];
    end
    return c;
  endfunction

  // Presents one command beat and holds it until the block takes it.
  task automatic issue(input cmd_t c);
    @(negedge clk);
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  // Sender drops start and idles before the next command.
  task automatic pause(input int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Sender stops until every outstanding result has come back.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (chk_pending != 0) @(negedge clk);
  endtask

  task automatic write_types(input logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_types = v;
  endtask

  // One random phase under a given type count; a calm window has no random pauses.
  task automatic run_phase(input logic [CFG_W-1:0] types, input int n,
                           input int calm_from, input int calm_to);
    int gap_pct;
    drain();
    write_types(types);
    foreach (pool[i]) pool[i] = ENTITY_FIELD_W'($urandom_range(ENTITY_SPACE - 1, 0));
    for (int k = 0; k < n; k++) begin
      gap_pct = (k >= calm_from && k < calm_to) ? 0 : 10;
      if ($urandom_range(99, 0) < gap_pct) pause($urandom_range(6, 1));
      if ($urandom_range(59, 0) == 0) drain();
      issue(random_cmd());
    end
  endtask

  initial begin : stimulus
    int total;
    rst       = 1'b1;
    start     = 1'b0;
    cmd       = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    sent      = 0;
    cur_types = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // No type is usable until the register is written.
    issue(make_cmd(REQ_PUSH, 1, 5, 64'h1234));
    issue(make_cmd(REQ_LOOKUP, 0, 0, '0));
    drain();
    write_types(3'd7);

    // Extremes of the fields, a duplicate push, misses, and swap-remove
    // both with a moved element and of the last element itself.
    issue(make_cmd(REQ_PUSH, 7, 1023, '1));
    issue(make_cmd(REQ_PUSH, 7, 0, '0));
    issue(make_cmd(REQ_PUSH, 1, 0, 64'h5555_5555_5555_5555));
    issue(make_cmd(REQ_LOOKUP, 7, 1023, '0));
    issue(make_cmd(REQ_LOOKUP, 7, 0, '1));
    issue(make_cmd(REQ_PROBE, 7, 1023, '0));
    issue(make_cmd(REQ_PUSH, 7, 0, 64'hDEAD_BEEF));
    issue(make_cmd(REQ_LOOKUP, 7, 512, '0));
    issue(make_cmd(REQ_REMOVE, 7, 512, '0));
    issue(make_cmd(REQ_REMOVE, 7, 1023, '0));
    issue(make_cmd(REQ_LOOKUP, 7, 0, '0));
    issue(make_cmd(REQ_REMOVE, 7, 0, '0));
    issue(make_cmd(REQ_LOOKUP, 7, 0, '0));
    issue(make_cmd(REQ_PUSH, 0, 1023, '1));
    issue(make_cmd(REQ_REMOVE, 0, 0, '0));
    issue(make_cmd(REQ_PUSH, 1, 'h2AA, 64'hAAAA_AAAA_AAAA_AAAA));
    issue(make_cmd(REQ_PUSH, 1, 'h155, 64'h0F0F_0F0F_0F0F_0F0F));
    issue(make_cmd(REQ_REMOVE, 1, 0, '0));
    issue(make_cmd(REQ_LOOKUP, 1, 'h155, '0));
    issue(make_cmd(REQ_PROBE, 1, 'h2AA, '0));
    issue(make_cmd(REQ_LOOKUP, 1, 'h2AA, '0));

    // Random phases; sets of types above a lowered count come back later.
    run_phase(3'd7, 200, 50, 150);
    run_phase(3'd3, 180, 0, 0);
    run_phase(3'd0, 30, 0, 0);
    run_phase(3'd7, 120, 0, 0);

    drain();
    repeat (TAIL) @(negedge clk);
    total = chk_errors + chk_pending;
    $display("Sent %0d commands and compared %0d results, with 0, 3 and 7 usable types,",
             sent, chk_results);
    $display("covering swap-removes, duplicates, misses, probes and invalid types.");
    if (total == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
